/* design/serial_command_retry_link_assert.svh */
// Assertion helpers for the serial command link, used by scrl_back.
`ifndef SERIAL_COMMAND_RETRY_LINK_ASSERT_SVH
`define SERIAL_COMMAND_RETRY_LINK_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SCRL_ASSERT_IMP(name, clk, rstn, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SCRL_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/scrl_pkg.sv */
package scrl_pkg;

	localparam int RX_DEPTH = 16;
	localparam int RX_AW = $clog2(RX_DEPTH);
	localparam int RX_CW = $clog2(RX_DEPTH + 1);

	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW = $clog2(QUEUE_DEPTH + 1);

	localparam int FRAME_LEN = 6;
	localparam int MIN_FRAME_LEN = 4;

	localparam logic [7:0] SYNC_0 = 8'h55;
	localparam logic [7:0] SYNC_1 = 8'hAA;
	localparam logic [7:0] SEQ_TOP = 8'd200;
	localparam logic [7:0] EXPECT_FF = 8'hFF;

	localparam logic [7:0] CODE_EQ = 8'h01;
	localparam logic [7:0] CODE_TREBLE = 8'h02;
	localparam logic [7:0] CODE_BASS = 8'h03;
	localparam logic [7:0] CODE_VIBRATION = 8'h05;
	localparam logic [7:0] CODE_QUERY_A = 8'h09;
	localparam logic [7:0] CODE_QUERY_B = 8'h0A;

	localparam logic [1:0] FUNC_CMD = 2'd0;
	localparam logic [1:0] FUNC_RX = 2'd1;
	localparam logic [1:0] FUNC_IDLE = 2'd2;
	localparam logic [1:0] FUNC_TICK = 2'd3;

	localparam logic KIND_TX = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	localparam logic [2:0] OUTCOME_NONE = 3'd0;
	localparam logic [2:0] OUTCOME_APPLIED = 3'd1;
	localparam logic [2:0] OUTCOME_NO_SETTING = 3'd2;
	localparam logic [2:0] OUTCOME_GAVE_UP = 3'd3;
	localparam logic [2:0] OUTCOME_REFUSED = 3'd4;

	localparam int CFG_IW = 1;
	localparam int CFG_DW = 16;
	localparam logic [CFG_IW-1:0] CFG_REPLY_TIMEOUT = 1'd0;
	localparam logic [CFG_IW-1:0] CFG_RETRY_LIMIT = 1'd1;

	localparam logic [15:0] REPLY_TIMEOUT_RESET = 16'd200;
	localparam logic [2:0] RETRY_LIMIT_RESET = 3'd3;
	localparam logic [7:0] EQ_RESET = 8'd1;
	localparam logic [7:0] TREBLE_RESET = 8'd50;
	localparam logic [7:0] BASS_RESET = 8'd50;
	localparam logic [7:0] VIBRATION_RESET = 8'd0;

	typedef enum logic [1:0] {
		OP_CMD,
		OP_RX,
		OP_IDLE,
		OP_TICK
	} op_t;

	typedef struct packed {
		op_t op;
		logic [7:0] code;
		logic [7:0] value;
		logic [7:0] rx_byte;
		logic expect_ff;
	} work_t;

	typedef struct packed {
		logic kind;
		logic [7:0] tx_byte;
		logic last;
		logic [2:0] outcome;
		logic [7:0] eq_mode;
		logic [7:0] treble_level;
		logic [7:0] bass_level;
		logic [7:0] vibration_level;
		logic busy_res;
	} result_t;

endpackage

/* design/scrl_if.sv */
interface scrl_item_if;
	logic valid;
	logic ready;
	logic [1:0] func;
	logic [7:0] cmd_code;
	logic [7:0] cmd_value;
	logic [7:0] rx_byte;

	modport source(output valid, func, cmd_code, cmd_value, rx_byte, input ready);
	modport sink(input valid, func, cmd_code, cmd_value, rx_byte, output ready);
endinterface

interface scrl_result_if;
	logic valid;
	logic ready;
	logic kind;
	logic [7:0] tx_byte;
	logic last;
	logic [2:0] outcome;
	logic [7:0] eq_mode;
	logic [7:0] treble_level;
	logic [7:0] bass_level;
	logic [7:0] vibration_level;
	logic busy_res;

	modport source(output valid, kind, tx_byte, last, outcome, eq_mode, treble_level,
		bass_level, vibration_level, busy_res, input ready);
	modport sink(input valid, kind, tx_byte, last, outcome, eq_mode, treble_level,
		bass_level, vibration_level, busy_res, output ready);
endinterface

/* design/serial_command_retry_link.sv */
// Command link with framed sends, reply matching and timed resends.
// Input words arrive on item (valid/ready): func selects a command, a received
// line byte, a line-idle event or a timer tick. Result words leave on result:
// six transmit words per frame sent, one status word, or both, with last on the final
// word that an input word causes. Registers are written through cfg_we, cfg_index
// and cfg_wdata; the user must write them only while the block is idle, which the
// block does not enforce. Index 0 is the reply timeout in ticks, index 1 the
// retry limit. A two-entry queue sits in front of the sequencer, so inputs are
// taken while earlier work is still being answered. Received bytes and ticks that
// cause no resend leave the sequencer idle. An accepted command's first frame
// byte is loaded into the output register once the sequencer is in its send
// state, then one byte a cycle while the output is not stalled. A line-idle check
// reads the receive store one byte a cycle, then checks the frame and offers its
// status word, if any. A stalled receiver holds the output register; the
// sequencer waits on it and the queue fills, after which item.ready falls.
// Reset clears all control state and the sequence number and sets the settings to
// their reset values; the receive store is not cleared and needs no clearing pass.
module serial_command_retry_link (
	input logic clk,
	input logic arst_n,
	scrl_item_if.sink item,
	scrl_result_if.source result,
	input logic cfg_we,
	input logic [scrl_pkg::CFG_IW-1:0] cfg_index,
	input logic [scrl_pkg::CFG_DW-1:0] cfg_wdata
);

	logic work_valid;
	logic work_ready;
	scrl_pkg::work_t work;

	scrl_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.item(item),
		.work_valid(work_valid),
		.work_ready(work_ready),
		.work(work)
	);

	scrl_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.work_valid(work_valid),
		.work_ready(work_ready),
		.work(work),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

endmodule

/* design/scrl_ram.sv */
module scrl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* design/scrl_front.sv */
module scrl_front (
	input logic clk,
	input logic arst_n,
	scrl_item_if.sink item,
	output logic work_valid,
	input logic work_ready,
	output scrl_pkg::work_t work
);

	scrl_pkg::work_t entry_q [scrl_pkg::QUEUE_DEPTH];
	scrl_pkg::work_t incoming;
	logic [scrl_pkg::QUEUE_AW-1:0] wr_ptr_q;
	logic [scrl_pkg::QUEUE_AW-1:0] rd_ptr_q;
	logic [scrl_pkg::QUEUE_CW-1:0] count_q;
	logic push;
	logic pop;

	always_comb begin
		incoming.op = scrl_pkg::OP_TICK;
		unique case (item.func)
			scrl_pkg::FUNC_CMD: incoming.op = scrl_pkg::OP_CMD;
			scrl_pkg::FUNC_RX: incoming.op = scrl_pkg::OP_RX;
			scrl_pkg::FUNC_IDLE: incoming.op = scrl_pkg::OP_IDLE;
			scrl_pkg::FUNC_TICK: incoming.op = scrl_pkg::OP_TICK;
		endcase
		incoming.code = item.cmd_code;
		incoming.value = item.cmd_value;
		incoming.rx_byte = item.rx_byte;
		// Query codes are answered with 0xFF in byte 3 rather than the sequence number.
		incoming.expect_ff = (item.cmd_code == scrl_pkg::CODE_QUERY_A) ||
			(item.cmd_code == scrl_pkg::CODE_QUERY_B);
	end

	assign item.ready = count_q != scrl_pkg::QUEUE_CW'(scrl_pkg::QUEUE_DEPTH);
	assign work_valid = count_q != '0;
	assign work = entry_q[rd_ptr_q];
	assign push = item.valid && item.ready;
	assign pop = work_valid && work_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == scrl_pkg::QUEUE_AW'(scrl_pkg::QUEUE_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == scrl_pkg::QUEUE_AW'(scrl_pkg::QUEUE_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= incoming;
		end
	end

endmodule

/* design/scrl_back.sv */
`include "serial_command_retry_link_assert.svh"

module scrl_back (
	input logic clk,
	input logic arst_n,
	input logic work_valid,
	output logic work_ready,
	input scrl_pkg::work_t work,
	scrl_result_if.source result,
	input logic cfg_we,
	input logic [scrl_pkg::CFG_IW-1:0] cfg_index,
	input logic [scrl_pkg::CFG_DW-1:0] cfg_wdata
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEND,
		ST_SUM,
		ST_CHECK,
		ST_STATUS
	} state_t;

	localparam logic [2:0] FRAME_LAST = 3'(scrl_pkg::FRAME_LEN - 1);

	state_t state_q;
	logic [15:0] reply_timeout_q;
	logic [2:0] retry_limit_q;
	logic [7:0] seq_q;
	logic [7:0] pcode_q;
	logic [7:0] pval_q;
	logic [7:0] expect_q;
	logic wait_q;
	logic [15:0] timer_q;
	logic [2:0] tos_q;
	logic [scrl_pkg::RX_CW-1:0] rx_count_q;
	logic [7:0] eq_q;
	logic [7:0] treble_q;
	logic [7:0] bass_q;
	logic [7:0] vib_q;
	logic [2:0] frame_idx_q;
	logic giveup_q;
	logic [2:0] status_q;
	logic [scrl_pkg::RX_CW-1:0] rd_ptr_q;
	logic [scrl_pkg::RX_CW-1:0] idx_s1;
	logic pend_s1;
	logic [7:0] sum_q;
	logic [7:0] b3_q;
	logic hdr_ok_q;
	logic res_valid_q;
	scrl_pkg::result_t res_q;

	logic slot_free;
	logic pop;
	logic load;
	logic emit_req;
	scrl_pkg::result_t emit_word;
	logic [7:0] seq_next;
	logic [15:0] timer_inc;
	logic [2:0] tos_next;
	logic [7:0] frame_sum;
	logic [7:0] frame_byte;
	logic [scrl_pkg::RX_CW-1:0] last_idx;
	logic setting_hit;
	logic accept_reply;
	logic apply;
	logic ram_we;
	logic ram_re;
	logic [7:0] ram_rdata;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reply_timeout_q <= scrl_pkg::REPLY_TIMEOUT_RESET;
			retry_limit_q <= scrl_pkg::RETRY_LIMIT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				scrl_pkg::CFG_REPLY_TIMEOUT: reply_timeout_q <= cfg_wdata;
				scrl_pkg::CFG_RETRY_LIMIT: retry_limit_q <= cfg_wdata[2:0];
			endcase
		end
	end

	assign slot_free = !res_valid_q || result.ready;
	assign work_ready = state_q == ST_IDLE;
	assign pop = work_valid && work_ready;

	assign seq_next = (seq_q < scrl_pkg::SEQ_TOP) ? seq_q + 8'd1 : 8'd0;
	assign timer_inc = timer_q + 16'd1;
	assign tos_next = (tos_q == 3'd7) ? 3'd7 : tos_q + 3'd1;
	assign frame_sum = scrl_pkg::SYNC_0 + scrl_pkg::SYNC_1 + seq_q + pcode_q + pval_q;
	assign last_idx = rx_count_q - scrl_pkg::RX_CW'(1);
	assign setting_hit = (pcode_q == scrl_pkg::CODE_EQ) || (pcode_q == scrl_pkg::CODE_TREBLE) ||
		(pcode_q == scrl_pkg::CODE_BASS) || (pcode_q == scrl_pkg::CODE_VIBRATION);
	assign accept_reply = hdr_ok_q && wait_q && (b3_q == expect_q);
	assign apply = (b3_q == seq_q) && setting_hit;

	always_comb begin
		unique case (frame_idx_q)
			3'd0: frame_byte = scrl_pkg::SYNC_0;
			3'd1: frame_byte = scrl_pkg::SYNC_1;
			3'd2: frame_byte = seq_q;
			3'd3: frame_byte = pcode_q;
			3'd4: frame_byte = pval_q;
			default: frame_byte = frame_sum;
		endcase
	end

	// The settings and busy flag are already final for the item being answered.
	always_comb begin
		emit_req = (state_q == ST_SEND) || (state_q == ST_STATUS);
		emit_word.kind = (state_q == ST_STATUS) ? scrl_pkg::KIND_STATUS : scrl_pkg::KIND_TX;
		emit_word.tx_byte = (state_q == ST_SEND) ? frame_byte : 8'd0;
		emit_word.last = (state_q == ST_STATUS) || ((frame_idx_q == FRAME_LAST) && !giveup_q);
		emit_word.outcome = (state_q == ST_STATUS) ? status_q : scrl_pkg::OUTCOME_NONE;
		emit_word.eq_mode = eq_q;
		emit_word.treble_level = treble_q;
		emit_word.bass_level = bass_q;
		emit_word.vibration_level = vib_q;
		emit_word.busy_res = wait_q;
	end

	assign load = emit_req && slot_free;

	assign ram_we = pop && (work.op == scrl_pkg::OP_RX) &&
		(rx_count_q < scrl_pkg::RX_CW'(scrl_pkg::RX_DEPTH));
	assign ram_re = (state_q == ST_SUM) && (rd_ptr_q < rx_count_q);

	scrl_ram #(
		.WIDTH(8),
		.DEPTH(scrl_pkg::RX_DEPTH)
	) u_rx_store (
		.clk(clk),
		.we(ram_we),
		.waddr(rx_count_q[scrl_pkg::RX_AW-1:0]),
		.wdata(work.rx_byte),
		.re(ram_re),
		.raddr(rd_ptr_q[scrl_pkg::RX_AW-1:0]),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			seq_q <= '0;
			pcode_q <= '0;
			pval_q <= '0;
			expect_q <= '0;
			wait_q <= 1'b0;
			timer_q <= '0;
			tos_q <= '0;
			rx_count_q <= '0;
			eq_q <= scrl_pkg::EQ_RESET;
			treble_q <= scrl_pkg::TREBLE_RESET;
			bass_q <= scrl_pkg::BASS_RESET;
			vib_q <= scrl_pkg::VIBRATION_RESET;
			frame_idx_q <= '0;
			giveup_q <= 1'b0;
			status_q <= scrl_pkg::OUTCOME_NONE;
			rd_ptr_q <= '0;
			idx_s1 <= '0;
			pend_s1 <= 1'b0;
			sum_q <= '0;
			b3_q <= '0;
			hdr_ok_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (load) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
			pend_s1 <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (work_valid) begin
						unique case (work.op)
							scrl_pkg::OP_CMD: begin
								if (wait_q) begin
									status_q <= scrl_pkg::OUTCOME_REFUSED;
									state_q <= ST_STATUS;
								end else begin
									seq_q <= seq_next;
									pcode_q <= work.code;
									pval_q <= work.value;
									expect_q <= work.expect_ff ? scrl_pkg::EXPECT_FF : seq_next;
									wait_q <= 1'b1;
									timer_q <= '0;
									tos_q <= '0;
									frame_idx_q <= '0;
									giveup_q <= 1'b0;
									state_q <= ST_SEND;
								end
							end
							scrl_pkg::OP_RX: begin
								// Bytes beyond the store are dropped.
								if (rx_count_q < scrl_pkg::RX_CW'(scrl_pkg::RX_DEPTH)) begin
									rx_count_q <= rx_count_q + 1'b1;
								end
							end
							scrl_pkg::OP_IDLE: begin
								if (rx_count_q > scrl_pkg::RX_CW'(scrl_pkg::MIN_FRAME_LEN)) begin
									rd_ptr_q <= '0;
									sum_q <= '0;
									hdr_ok_q <= 1'b1;
									state_q <= ST_SUM;
								end else begin
									rx_count_q <= '0;
								end
							end
							scrl_pkg::OP_TICK: begin
								if (wait_q) begin
									if (timer_inc >= reply_timeout_q) begin
										timer_q <= '0;
										tos_q <= tos_next;
										frame_idx_q <= '0;
										giveup_q <= tos_next >= retry_limit_q;
										if (tos_next >= retry_limit_q) begin
											wait_q <= 1'b0;
										end
										state_q <= ST_SEND;
									end else begin
										timer_q <= timer_inc;
									end
								end
							end
						endcase
					end
				end
				ST_SEND: begin
					if (slot_free) begin
						if (frame_idx_q == FRAME_LAST) begin
							status_q <= scrl_pkg::OUTCOME_GAVE_UP;
							state_q <= giveup_q ? ST_STATUS : ST_IDLE;
						end else begin
							frame_idx_q <= frame_idx_q + 3'd1;
						end
					end
				end
				ST_SUM: begin
					// Reads run ahead of the checks; the read data lands in the next cycle.
					if (ram_re) begin
						rd_ptr_q <= rd_ptr_q + 1'b1;
						idx_s1 <= rd_ptr_q;
						pend_s1 <= 1'b1;
					end
					if (pend_s1) begin
						if ((idx_s1 == scrl_pkg::RX_CW'(0)) && (ram_rdata != scrl_pkg::SYNC_0)) begin
							hdr_ok_q <= 1'b0;
						end
						if ((idx_s1 == scrl_pkg::RX_CW'(1)) && (ram_rdata != scrl_pkg::SYNC_1)) begin
							hdr_ok_q <= 1'b0;
						end
						if (idx_s1 == scrl_pkg::RX_CW'(3)) begin
							b3_q <= ram_rdata;
						end
						if (idx_s1 == last_idx) begin
							if (ram_rdata != sum_q) begin
								hdr_ok_q <= 1'b0;
							end
						end else begin
							sum_q <= sum_q + ram_rdata;
						end
					end
					if (!ram_re && !pend_s1) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					rx_count_q <= '0;
					if (accept_reply) begin
						wait_q <= 1'b0;
						status_q <= apply ? scrl_pkg::OUTCOME_APPLIED : scrl_pkg::OUTCOME_NO_SETTING;
						if (b3_q == seq_q) begin
							unique case (pcode_q)
								scrl_pkg::CODE_EQ: eq_q <= pval_q;
								scrl_pkg::CODE_TREBLE: treble_q <= pval_q;
								scrl_pkg::CODE_BASS: bass_q <= pval_q;
								scrl_pkg::CODE_VIBRATION: vib_q <= pval_q;
								default: ;
							endcase
						end
						state_q <= ST_STATUS;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_STATUS: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= emit_word;
		end
	end

	assign result.valid = res_valid_q;
	assign result.kind = res_q.kind;
	assign result.tx_byte = res_q.tx_byte;
	assign result.last = res_q.last;
	assign result.outcome = res_q.outcome;
	assign result.eq_mode = res_q.eq_mode;
	assign result.treble_level = res_q.treble_level;
	assign result.bass_level = res_q.bass_level;
	assign result.vibration_level = res_q.vibration_level;
	assign result.busy_res = res_q.busy_res;

	`SCRL_ASSERT_IMP(a_frame_idx, clk, arst_n, state_q == ST_SEND, frame_idx_q <= FRAME_LAST, "frame index past end of frame")
	`SCRL_ASSERT_IMP(a_rx_bound, clk, arst_n, 1'b1, rx_count_q <= scrl_pkg::RX_CW'(scrl_pkg::RX_DEPTH), "receive count beyond store depth")
	`SCRL_ASSERT_IMP(a_giveup_idle, clk, arst_n, load && (emit_word.outcome == scrl_pkg::OUTCOME_GAVE_UP), !wait_q, "give-up reported while still waiting")
	`SCRL_ASSERT_NEXT(a_cmd_starts, clk, arst_n, pop && (work.op == scrl_pkg::OP_CMD) && !wait_q, (state_q == ST_SEND) && wait_q, "accepted command did not start a frame")

endmodule
